// File: design/bsmv_pkg.sv
package bsmv_pkg;

   localparam int VECTOR_DEPTH_DEF  = 1024;
   localparam int MAX_BLOCK_DIM_DEF = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_HEIGHT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BLOCK_WIDTH  = 2'd1;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_ELEM  = 2'd1,
      ACT_CLOSE = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_MUL,
      ST_ACC,
      ST_CLOSE
   } state_type;

   typedef struct packed {
      logic capture;
      logic store_write;
      logic mem_read;
      logic multiply;
      logic accumulate;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic elem_inside;
      logic row_last;
      logic out_free;
   } status_type;

endpackage

// File: design/bsmv_ctrl.sv
module bsmv_ctrl
   import bsmv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (action_type'(req_action))
                  ACT_LOAD:  state_in = ST_LOAD;
                  ACT_ELEM:  state_in = ST_READ;
                  ACT_CLOSE: state_in = ST_CLOSE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.store_write = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_READ: begin
            if (status.elem_inside) begin
               cmd.mem_read = 1'b1;
               state_in     = ST_MUL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_CLOSE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.row_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/bsmv_datapath.sv
module bsmv_datapath
   import bsmv_pkg::*;
#(
   parameter int VECTOR_DEPTH  = VECTOR_DEPTH_DEF,
   parameter int MAX_BLOCK_DIM = MAX_BLOCK_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [9:0]             req_x_index,
   input  logic signed [31:0]     req_x_value,
   input  logic [7:0]             req_block_row,
   input  logic [7:0]             req_block_col,
   input  logic [1:0]             req_elem_col,
   input  logic [1:0]             req_elem_row,
   input  logic signed [31:0]     req_a_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_block_row,
   output logic [1:0]             rsp_row_offset,
   output logic signed [31:0]     rsp_sum,
   output logic                   rsp_last,
   output logic                   rsp_range_error
);

   localparam int ADDR_W = $clog2(VECTOR_DEPTH);
   localparam int DIM_W  = $clog2(MAX_BLOCK_DIM + 1);
   localparam int ROW_W  = (MAX_BLOCK_DIM > 1) ? $clog2(MAX_BLOCK_DIM) : 1;
   localparam int XI_W   = 8 + DIM_W;
   localparam int POS_W  = DIM_W + 2;

   logic [CSR_DATA_W-1:0] height_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic                  err_ff;

   logic [9:0]         x_index_ff;
   logic signed [31:0] x_value_ff;
   logic [7:0]         block_row_ff;
   logic [7:0]         block_col_ff;
   logic [1:0]         elem_col_ff;
   logic [1:0]         elem_row_ff;
   logic signed [31:0] a_value_ff;

   logic signed [31:0] vec_mem [VECTOR_DEPTH];
   logic signed [31:0] rd_ff;
   logic               xok_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [31:0] xv;

   logic signed [63:0] acc_ff [MAX_BLOCK_DIM];
   logic [ROW_W-1:0]   r_ff;
   logic [ROW_W-1:0]   acc_idx;
   logic signed [63:0] acc_rd;
   logic signed [63:0] shifted;
   logic signed [64:0] acc_wide;
   logic signed [63:0] acc_in;
   logic signed [31:0] sum_sat;

   logic [DIM_W-1:0] eff_h;
   logic [DIM_W-1:0] eff_w;
   logic [XI_W-1:0]  xi;
   logic             xi_ok;
   logic             load_ok;

   logic               rsp_valid_ff;
   logic [7:0]         out_block_row_ff;
   logic [1:0]         row_offset_ff;
   logic signed [31:0] sum_ff;
   logic               last_ff;
   logic               range_error_ff;

   always_comb begin
      priority if (height_ff == '0) begin
         eff_h = DIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_BLOCK_DIM)) begin
         eff_h = DIM_W'(MAX_BLOCK_DIM);
      end else begin
         eff_h = DIM_W'(height_ff);
      end
      priority if (width_ff == '0) begin
         eff_w = DIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_BLOCK_DIM)) begin
         eff_w = DIM_W'(MAX_BLOCK_DIM);
      end else begin
         eff_w = DIM_W'(width_ff);
      end
   end

   assign xi      = XI_W'(block_col_ff) * XI_W'(eff_w) + XI_W'(elem_col_ff);
   assign xi_ok   = 32'(xi) < 32'(VECTOR_DEPTH);
   assign load_ok = 32'(x_index_ff) < 32'(VECTOR_DEPTH);

   assign status.elem_inside = (POS_W'(elem_row_ff) < POS_W'(eff_h))
                            && (POS_W'(elem_col_ff) < POS_W'(eff_w));
   assign status.row_last    = (DIM_W'(r_ff) + DIM_W'(1)) == eff_h;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= CSR_DATA_W'(1);
         width_ff  <= CSR_DATA_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BLOCK_HEIGHT: height_ff <= csr_data;
            REG_BLOCK_WIDTH:  width_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_index_ff   <= req_x_index;
         x_value_ff   <= req_x_value;
         block_row_ff <= req_block_row;
         block_col_ff <= req_block_col;
         elem_col_ff  <= req_elem_col;
         elem_row_ff  <= req_elem_row;
         a_value_ff   <= req_a_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_write && load_ok) begin
         vec_mem[ADDR_W'(x_index_ff)] <= x_value_ff;
      end
      if (cmd.mem_read) begin
         rd_ff  <= vec_mem[ADDR_W'(xi)];
         xok_ff <= xi_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= 1'b0;
      end else if ((cmd.store_write && !load_ok) || (cmd.mem_read && !xi_ok)) begin
         err_ff <= 1'b1;
      end
   end

   assign xv      = xok_ff ? rd_ff : '0;
   assign prod_in = a_value_ff * xv;

   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         prod_ff <= prod_in;
      end
   end

   assign acc_idx  = cmd.emit ? r_ff : ROW_W'(elem_row_ff);
   assign acc_rd   = acc_ff[acc_idx];
   assign shifted  = prod_ff >>> 16;
   assign acc_wide = {acc_rd[63], acc_rd} + {shifted[63], shifted};

   always_comb begin
      if (acc_wide[64] != acc_wide[63]) begin
         acc_in = acc_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         acc_in = acc_wide[63:0];
      end
      if (acc_rd[63:31] != {33{acc_rd[63]}}) begin
         sum_sat = acc_rd[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
      end else begin
         sum_sat = acc_rd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < MAX_BLOCK_DIM; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (cmd.accumulate) begin
         acc_ff[acc_idx] <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         r_ff <= '0;
      end else if (cmd.emit) begin
         r_ff <= r_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_block_row_ff <= block_row_ff;
         row_offset_ff    <= 2'(r_ff);
         sum_ff           <= sum_sat;
         last_ff          <= status.row_last;
         range_error_ff   <= err_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_block_row = out_block_row_ff;
   assign rsp_row_offset    = row_offset_ff;
   assign rsp_sum           = sum_ff;
   assign rsp_last          = last_ff;
   assign rsp_range_error   = range_error_ff;

endmodule

// File: design/block_sparse_matvec.sv
// Block-sparse matrix times vector in signed Q16.16. A load item writes one vector element
// into an internal store, an element item multiplies one nonzero block entry by the vector
// element at block_col * block_width + elem_col and adds it into the accumulator of its row,
// and a close item emits one saturated row sum per row of the block, marks the last one, and
// clears the accumulators. The block height and width registers act as if limited to the
// range 1 to MAX_BLOCK_DIM. Items are handled one at a time by a small controller: a load
// writes the store; an element reads the store, does the registered 32 x 32 multiply and
// the 64-bit saturating accumulate, ending at the read step if outside the block; a close
// emits its row sums in turn, holding while the result register waits on rsp_ready. The
// next item is taken while the final sum of a close still waits in the result register.
// The vector store is not cleared at reset and must be loaded before it is used.
// Configuration writes are always taken and should only be made while the block is idle.
module block_sparse_matvec
   import bsmv_pkg::*;
#(
   parameter int VECTOR_DEPTH  = VECTOR_DEPTH_DEF,
   parameter int MAX_BLOCK_DIM = MAX_BLOCK_DIM_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_action,
   input  logic [9:0]             req_x_index,
   input  logic signed [31:0]     req_x_value,
   input  logic [7:0]             req_block_row,
   input  logic [7:0]             req_block_col,
   input  logic [1:0]             req_elem_col,
   input  logic [1:0]             req_elem_row,
   input  logic signed [31:0]     req_a_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_block_row,
   output logic [1:0]             rsp_row_offset,
   output logic signed [31:0]     rsp_sum,
   output logic                   rsp_last,
   output logic                   rsp_range_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   bsmv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   bsmv_datapath #(
      .VECTOR_DEPTH  (VECTOR_DEPTH),
      .MAX_BLOCK_DIM (MAX_BLOCK_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_x_index       (req_x_index),
      .req_x_value       (req_x_value),
      .req_block_row     (req_block_row),
      .req_block_col     (req_block_col),
      .req_elem_col      (req_elem_col),
      .req_elem_row      (req_elem_row),
      .req_a_value       (req_a_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_block_row (rsp_out_block_row),
      .rsp_row_offset    (rsp_row_offset),
      .rsp_sum           (rsp_sum),
      .rsp_last          (rsp_last),
      .rsp_range_error   (rsp_range_error)
   );

endmodule

// File: design/bsmv_checker.sv
module bsmv_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [7:0]        rsp_out_block_row,
   input logic [1:0]        rsp_row_offset,
   input logic signed [31:0] rsp_sum,
   input logic              rsp_last,
   input logic              rsp_range_error
);

   logic [1:0] exp_off_ff;
   logic       mid_ff;
   logic [7:0] grp_row_ff;
   logic       seen_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_off_ff  <= '0;
         mid_ff      <= 1'b0;
         seen_err_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         exp_off_ff  <= rsp_last ? 2'd0 : exp_off_ff + 2'd1;
         mid_ff      <= !rsp_last;
         seen_err_ff <= seen_err_ff || rsp_range_error;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         grp_row_ff <= rsp_out_block_row;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum) && $stable(rsp_row_offset))
      else $error("result item changed while stalled");

   a_offset_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row_offset == exp_off_ff)
      else $error("row offset out of order within a block row");

   a_same_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mid_ff |-> rsp_out_block_row == grp_row_ff)
      else $error("block row changed inside a group of sums");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_err_ff |-> rsp_range_error)
      else $error("range error flag cleared without reset");

endmodule

bind block_sparse_matvec bsmv_checker u_bsmv_checker (.*);

// File: test/testbench.sv
module testbench;
   import bsmv_pkg::*;

   typedef struct packed {
      logic [1:0]         action;
      logic [9:0]         x_index;
      logic signed [31:0] x_value;
      logic [7:0]         block_row;
      logic [7:0]         block_col;
      logic [1:0]         elem_col;
      logic [1:0]         elem_row;
      logic signed [31:0] a_value;
   } matvec_item_t;

   typedef struct packed {
      logic [7:0]         block_row;
      logic [1:0]         row_offset;
      logic signed [31:0] sum;
      logic               last;
      logic               range_error;
   } row_sum_t;

   localparam int STALL_LIMIT = 2000;
   localparam longint SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam longint SUM_MIN = -64'sh0000_0000_8000_0000;
   localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ACC_MIN = 64'sh8000_0000_0000_0000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_action = 2'd0;
   logic [9:0]             req_x_index = 10'd0;
   logic signed [31:0]     req_x_value = 32'sd0;
   logic [7:0]             req_block_row = 8'd0;
   logic [7:0]             req_block_col = 8'd0;
   logic [1:0]             req_elem_col = 2'd0;
   logic [1:0]             req_elem_row = 2'd0;
   logic signed [31:0]     req_a_value = 32'sd0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_out_block_row;
   logic [1:0]             rsp_row_offset;
   logic signed [31:0]     rsp_sum;
   logic                   rsp_last;
   logic                   rsp_range_error;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   matvec_item_t pending_items[$];
   row_sum_t     expected_sums[$];
   matvec_item_t live_item;
   row_sum_t     want;

   logic signed [31:0] vec_mem [VECTOR_DEPTH_DEF];
   bit                 stored [VECTOR_DEPTH_DEF];
   longint             row_acc [MAX_BLOCK_DIM_DEF];
   logic               range_flag = 1'b0;
   logic [2:0]         cfg_height = 3'd1;
   logic [2:0]         cfg_width = 3'd1;

   int          fail_count = 0;
   int          items_queued = 0;
   int          quiet_cycles = 0;
   logic [31:0] cycle_count = 0;
   wire         calm = (cycle_count[9:8] == 2'b11);

   block_sparse_matvec dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_x_index       (req_x_index),
      .req_x_value       (req_x_value),
      .req_block_row     (req_block_row),
      .req_block_col     (req_block_col),
      .req_elem_col      (req_elem_col),
      .req_elem_row      (req_elem_row),
      .req_a_value       (req_a_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_block_row (rsp_out_block_row),
      .rsp_row_offset    (rsp_row_offset),
      .rsp_sum           (rsp_sum),
      .rsp_last          (rsp_last),
      .rsp_range_error   (rsp_range_error),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(input logic [2:0] raw);
      if (raw == 3'd0) return 1;
      if (raw > 3'(MAX_BLOCK_DIM_DEF)) return MAX_BLOCK_DIM_DEF;
      return int'(raw);
   endfunction

   function automatic longint sat_add(input longint a, input longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? ACC_MIN : ACC_MAX;
      return s;
   endfunction

   task automatic apply_item(input matvec_item_t it);
      int unsigned h;
      int unsigned w;
      int unsigned xi;
      longint      xv;
      longint      prod;
      longint      clipped;
      row_sum_t    rs;
      h = eff_dim(cfg_height);
      w = eff_dim(cfg_width);
      case (it.action)
         ACT_LOAD: begin
            if (int'(it.x_index) < VECTOR_DEPTH_DEF) vec_mem[it.x_index] = it.x_value;
            else range_flag = 1'b1;
         end
         ACT_ELEM: begin
            if (it.elem_row < h && it.elem_col < w) begin
               xi = it.block_col * w + it.elem_col;
               if (xi < VECTOR_DEPTH_DEF) begin
                  xv = longint'($signed(vec_mem[xi]));
               end else begin
                  xv = 0;
                  range_flag = 1'b1;
               end
               prod = longint'($signed(it.a_value)) * xv;
               row_acc[it.elem_row] = sat_add(row_acc[it.elem_row], prod >>> 16);
            end
         end
         ACT_CLOSE: begin
            for (int r = 0; r < h; r++) begin
               clipped = row_acc[r];
               if (clipped > SUM_MAX) clipped = SUM_MAX;
               if (clipped < SUM_MIN) clipped = SUM_MIN;
               rs.block_row = it.block_row;
               rs.row_offset = 2'(r);
               rs.sum = clipped[31:0];
               rs.last = (r == h - 1);
               rs.range_error = range_flag;
               expected_sums.push_back(rs);
            end
            foreach (row_acc[k]) row_acc[k] = 0;
         end
         default: begin
         end
      endcase
   endtask

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      fail_count++;
   endtask

   function automatic logic signed [31:0] pick_value();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 3))
         0: return r;
         1: return {{12{r[19]}}, r[19:0]};
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               3: return 32'h0001_0000;
               default: return 32'h0000_0000;
            endcase
         end
         default: return {{8{r[23]}}, r[23:0]};
      endcase
   endfunction

   function automatic matvec_item_t random_fields();
      matvec_item_t it;
      it.action = ACT_LOAD;
      it.x_index = 10'($urandom);
      it.x_value = $urandom;
      it.block_row = 8'($urandom);
      it.block_col = 8'($urandom);
      it.elem_col = 2'($urandom);
      it.elem_row = 2'($urandom);
      it.a_value = $urandom;
      return it;
   endfunction

   task automatic queue_item(input matvec_item_t it);
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic queue_load(input int idx, input logic signed [31:0] value);
      matvec_item_t it;
      it = random_fields();
      it.action = ACT_LOAD;
      it.x_index = 10'(idx);
      it.x_value = value;
      stored[idx] = 1'b1;
      queue_item(it);
   endtask

   // Every vector entry that an element can read is loaded before the element goes out.
   task automatic queue_element(input logic [7:0] brow, input logic [7:0] bcol,
                                input logic [1:0] ecol, input logic [1:0] erow,
                                input logic signed [31:0] a);
      matvec_item_t it;
      int           xi;
      xi = bcol * eff_dim(cfg_width) + ecol;
      if (xi < VECTOR_DEPTH_DEF && !stored[xi]) queue_load(xi, pick_value());
      it = random_fields();
      it.action = ACT_ELEM;
      it.block_row = brow;
      it.block_col = bcol;
      it.elem_col = ecol;
      it.elem_row = erow;
      it.a_value = a;
      queue_item(it);
   endtask

   task automatic queue_close(input logic [7:0] brow);
      matvec_item_t it;
      it = random_fields();
      it.action = ACT_CLOSE;
      it.block_row = brow;
      queue_item(it);
   endtask

   task automatic queue_noise();
      matvec_item_t it;
      it = random_fields();
      it.action = 2'd3;
      queue_item(it);
   endtask

   task automatic queue_random_phase(input int quota);
      int          stop_at;
      int          n;
      int          h;
      int          w;
      logic [7:0]  brow;
      logic [7:0]  bcol;
      logic [1:0]  ecol;
      logic [1:0]  erow;
      stop_at = items_queued + quota;
      h = eff_dim(cfg_height);
      w = eff_dim(cfg_width);
      while (items_queued < stop_at) begin
         brow = 8'($urandom);
         n = $urandom_range(0, 6);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 10) begin
               queue_load($urandom_range(0, VECTOR_DEPTH_DEF - 1), pick_value());
            end else if ($urandom_range(0, 99) < 4) begin
               queue_noise();
            end else begin
               bcol = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
               erow = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, h - 1))
                                                   : 2'($urandom);
               ecol = ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, w - 1))
                                                   : 2'($urandom);
               queue_element(($urandom_range(0, 99) < 70) ? brow : 8'($urandom),
                             bcol, ecol, erow, pick_value());
            end
         end
         if ($urandom_range(0, 99) < 90) queue_close(brow);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_BLOCK_HEIGHT) cfg_height = value;
      else if (idx == REG_BLOCK_WIDTH) cfg_width = value;
      @(negedge clock);
   endtask

   task automatic wait_for_drain(input int settle);
      do @(negedge clock);
      while (pending_items.size() > 0 || req_valid || expected_sums.size() > 0);
      repeat (settle) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_item(live_item);
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
               live_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_action <= live_item.action;
               req_x_index <= live_item.x_index;
               req_x_value <= live_item.x_value;
               req_block_row <= live_item.block_row;
               req_block_col <= live_item.block_col;
               req_elem_col <= live_item.elem_col;
               req_elem_row <= live_item.elem_row;
               req_a_value <= live_item.a_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               flag_mismatch($sformatf("unexpected item: block_row %0d offset %0d sum %h",
                                       rsp_out_block_row, rsp_row_offset, rsp_sum));
            end else begin
               want = expected_sums.pop_front();
               if (rsp_out_block_row !== want.block_row)
                  flag_mismatch($sformatf("out_block_row %0d, expected %0d",
                                          rsp_out_block_row, want.block_row));
               if (rsp_row_offset !== want.row_offset)
                  flag_mismatch($sformatf("row_offset %0d, expected %0d",
                                          rsp_row_offset, want.row_offset));
               if (rsp_sum !== want.sum)
                  flag_mismatch($sformatf("sum %h, expected %h (block_row %0d offset %0d)",
                                          rsp_sum, want.sum, want.block_row,
                                          want.row_offset));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last %b, expected %b", rsp_last, want.last));
               if (rsp_range_error !== want.range_error)
                  flag_mismatch($sformatf("range_error %b, expected %b",
                                          rsp_range_error, want.range_error));
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [2:0] heights [9];
      logic [2:0] widths [9];
      heights = '{3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd1, 3'd4, 3'd6, 3'd3};
      widths  = '{3'd4, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd1, 3'd5, 3'd3};
      foreach (row_acc[k]) row_acc[k] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One-by-one blocks: saturation both ways, flooring of a tiny negative product,
      // elements outside the block and an unknown action.
      queue_load(0, 32'h7FFF_FFFF);
      queue_load(1, 32'h8000_0000);
      queue_load(2, 32'hFFFF_FFFF);
      queue_load(1023, 32'h0001_0000);
      queue_element(8'hFF, 8'd0, 2'd0, 2'd0, 32'h7FFF_FFFF);
      queue_element(8'hFF, 8'd0, 2'd0, 2'd0, 32'h7FFF_FFFF);
      queue_close(8'hFF);
      queue_element(8'h00, 8'd1, 2'd0, 2'd0, 32'h7FFF_FFFF);
      queue_close(8'h00);
      queue_element(8'h5A, 8'd2, 2'd0, 2'd0, 32'sd1);
      queue_element(8'h5A, 8'd0, 2'd0, 2'd1, 32'h0001_0000);
      queue_element(8'h5A, 8'd0, 2'd3, 2'd0, 32'h0001_0000);
      queue_noise();
      queue_close(8'h5A);
      wait_for_drain(10);

      write_csr(REG_BLOCK_HEIGHT, 3'd4);
      write_csr(REG_BLOCK_WIDTH, 3'd4);
      queue_element(8'hA5, 8'd255, 2'd3, 2'd3, 32'h0002_0000);
      queue_element(8'hA5, 8'd0, 2'd0, 2'd0, 32'h0001_0000);
      queue_element(8'hA5, 8'd0, 2'd1, 2'd1, 32'h8000_0000);
      queue_element(8'hA5, 8'd0, 2'd2, 2'd2, 32'hFFFF_FFFF);
      queue_close(8'hA5);
      wait_for_drain(10);

      foreach (heights[p]) begin
         write_csr(REG_BLOCK_HEIGHT, heights[p]);
         write_csr(REG_BLOCK_WIDTH, widths[p]);
         queue_random_phase(50);
         wait_for_drain(10);
      end

      wait_for_drain(20);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: block_sparse_matvec.f
design/bsmv_pkg.sv
design/bsmv_ctrl.sv
design/bsmv_datapath.sv
design/block_sparse_matvec.sv
design/bsmv_checker.sv
test/testbench.sv
